// ----- design/lst_pkg.sv -----
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types, codes, character classes and the keyword table of the
// Lua-style tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

  localparam int unsigned MaxNestDefault = 15;
  localparam int unsigned NestCapMax     = 15;
  localparam int unsigned LineW          = 24;
  localparam int unsigned NestW          = 4;
  localparam int unsigned WordDepth      = 8;
  localparam int unsigned NumKw          = 21;

  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [4:0] BASE_NONE = 5'd0;
  localparam logic [4:0] BASE_2    = 5'd2;
  localparam logic [4:0] BASE_8    = 5'd8;
  localparam logic [4:0] BASE_10   = 5'd10;
  localparam logic [4:0] BASE_16   = 5'd16;

  localparam logic [5:0] TK_INVALID = 6'd0;
  localparam logic [5:0] TK_LPAREN  = 6'd22;
  localparam logic [5:0] TK_RPAREN  = 6'd23;
  localparam logic [5:0] TK_LBRACE  = 6'd24;
  localparam logic [5:0] TK_RBRACE  = 6'd25;
  localparam logic [5:0] TK_LBRACK  = 6'd26;
  localparam logic [5:0] TK_RBRACK  = 6'd27;
  localparam logic [5:0] TK_PLUS    = 6'd28;
  localparam logic [5:0] TK_MINUS   = 6'd29;
  localparam logic [5:0] TK_STAR    = 6'd30;
  localparam logic [5:0] TK_SLASH   = 6'd31;
  localparam logic [5:0] TK_PERCENT = 6'd32;
  localparam logic [5:0] TK_CARET   = 6'd33;
  localparam logic [5:0] TK_EQEQ    = 6'd34;
  localparam logic [5:0] TK_NE      = 6'd35;
  localparam logic [5:0] TK_LT      = 6'd36;
  localparam logic [5:0] TK_LE      = 6'd37;
  localparam logic [5:0] TK_GT      = 6'd38;
  localparam logic [5:0] TK_GE      = 6'd39;
  localparam logic [5:0] TK_HASH    = 6'd40;
  localparam logic [5:0] TK_DOT     = 6'd41;
  localparam logic [5:0] TK_CONCAT  = 6'd42;
  localparam logic [5:0] TK_DOTS    = 6'd43;
  localparam logic [5:0] TK_COMMA   = 6'd44;
  localparam logic [5:0] TK_SEMI    = 6'd46;
  localparam logic [5:0] TK_ASSIGN  = 6'd47;
  localparam logic [5:0] TK_IDENT   = 6'd48;
  localparam logic [5:0] TK_NUMBER  = 6'd49;
  localparam logic [5:0] TK_STRING  = 6'd50;
  localparam logic [5:0] TK_EOF     = 6'd51;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_CHAR       = 4'd1;
  localparam logic [3:0] ERR_LONG_OPEN  = 4'd2;
  localparam logic [3:0] ERR_ESCAPE     = 4'd3;
  localparam logic [3:0] ERR_STR_OPEN   = 4'd4;
  localparam logic [3:0] ERR_PREFIX     = 4'd5;
  localparam logic [3:0] ERR_NO_EQUAL   = 4'd6;
  localparam logic [3:0] ERR_NO_LBRACK  = 4'd7;
  localparam logic [3:0] ERR_NEST       = 4'd8;

  typedef enum logic [4:0] {
    M_IDLE, M_IDENT, M_NUM_ZERO, M_NUM_DEC, M_NUM_EXP, M_NUM_EXPDIG,
    M_NUM_TAIL, M_P2, M_P8, M_P10, M_P16, M_MINUS, M_CMT_START, M_CMT_BR,
    M_LINE_CMT, M_LONG_CMT, M_LONG_CMT_CLOSE, M_BRACKET, M_BRACKET_EQ,
    M_LONG_STR, M_LONG_STR_CLOSE, M_EQ, M_LT, M_GT, M_TILDE, M_DOT1,
    M_DOT2, M_STR, M_STR_ESC
  } mode_t;

  typedef struct packed {
    logic       is_token;
    logic [5:0] kind;
    logic [7:0] payload;
    logic [4:0] base;
    logic [3:0] err;
  } res_t;

  typedef struct packed {
    logic [4:0]       rep_len;
    logic [4:0]       total;
    res_t [1:0]       slot;
    logic [LineW-1:0] line;
  } desc_t;

  typedef struct packed {
    mode_t            mode;
    logic [LineW-1:0] line;
    logic [NestW-1:0] open_n;
    logic [NestW-1:0] close_n;
    logic             qd;
    logic [3:0]       wlen;
    logic             halted;
    logic             again;
    logic             use_new;
    logic [4:0]       rep_len;
    logic [1:0]       n;
    res_t [1:0]       slot;
    logic             wb_we;
    logic [2:0]       wb_idx;
    logic [7:0]       wb_data;
  } scan_t;

  localparam logic [63:0] KW_TEXT [NumKw] = '{
    64'("and"), 64'("break"), 64'("do"), 64'("else"), 64'("elseif"),
    64'("end"), 64'("false"), 64'("for"), 64'("function"), 64'("if"),
    64'("in"), 64'("local"), 64'("nil"), 64'("not"), 64'("or"),
    64'("repeat"), 64'("return"), 64'("then"), 64'("true"), 64'("until"),
    64'("while")
  };
  localparam logic [3:0] KW_LEN [NumKw] = '{
    4'd3, 4'd5, 4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd3, 4'd8, 4'd2, 4'd2,
    4'd5, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_letter(c) || is_digit(c);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "]":     k = TK_RBRACK;
      "+":     k = TK_PLUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      "%":     k = TK_PERCENT;
      "^":     k = TK_CARET;
      "#":     k = TK_HASH;
      ",":     k = TK_COMMA;
      ";":     k = TK_SEMI;
      default: k = TK_INVALID;
    endcase
    return k;
  endfunction

  // {valid, value}
  function automatic logic [8:0] esc_value(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      "0":     v = {1'b1, 8'd0};
      "a":     v = {1'b1, 8'd7};
      "b":     v = {1'b1, 8'd8};
      "f":     v = {1'b1, 8'd12};
      "n":     v = {1'b1, 8'd10};
      "t":     v = {1'b1, 8'd9};
      "r":     v = {1'b1, 8'd13};
      "v":     v = {1'b1, 8'd11};
      CH_NL, "'", "\"", "\\": v = {1'b1, c};
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] kw_kind(input logic [WordDepth-1:0][7:0] wbuf,
                                         input logic [3:0] len);
    logic [5:0] k;
    logic       hit;
    k = TK_IDENT;
    for (int kk = NumKw - 1; kk >= 0; kk--) begin
      hit = (len == KW_LEN[kk]);
      for (int i = 0; i < WordDepth; i++) begin
        if (i < int'(KW_LEN[kk])) begin
          if (wbuf[i] != KW_TEXT[kk][(int'(KW_LEN[kk]) - 1 - i) * 8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        k = 6'(kk + 1);
      end
    end
    return k;
  endfunction

  function automatic res_t mk_byte(input logic [7:0] b);
    return '{1'b0, TK_INVALID, b, BASE_NONE, ERR_NONE};
  endfunction

  function automatic res_t mk_tok(input logic [5:0] k, input logic [4:0] base);
    return '{1'b1, k, 8'd0, base, ERR_NONE};
  endfunction

  function automatic res_t mk_err(input logic [3:0] e);
    return '{1'b1, TK_INVALID, 8'd0, BASE_NONE, e};
  endfunction

endpackage

`default_nettype wire

// ----- design/lst_scan.sv -----
// ----------------------------------------------------------------------------
// lst_scan
// Scanner state and the per-byte step: turns one accepted byte into a
// result descriptor (close replay plus up to two results).
// ----------------------------------------------------------------------------
`default_nettype none

module lst_scan #(
  parameter int unsigned MAX_NEST = lst_pkg::MaxNestDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     source_byte,
  input  wire logic           end_of_stream,
  output lst_pkg::desc_t      desc
);
  import lst_pkg::*;

  localparam logic [NestW-1:0] NestCap =
    NestW'((MAX_NEST < NestCapMax) ? MAX_NEST : NestCapMax);

  mode_t                       mode;
  logic [LineW-1:0]            line_count;
  logic [NestW-1:0]            open_nesting;
  logic [NestW-1:0]            close_nesting;
  logic                        quote_is_double;
  logic [3:0]                  word_length;
  logic [WordDepth-1:0][7:0]   word_buffer;
  logic                        halted;
  scan_t                       s;

  function automatic scan_t put(input scan_t si, input res_t r);
    scan_t so;
    so = si;
    if (so.n == 2'd0) begin
      so.slot[0] = r;
    end else begin
      so.slot[1] = r;
    end
    so.n = so.n + 2'd1;
    return so;
  endfunction

  function automatic scan_t fail(input scan_t si, input logic [3:0] e);
    scan_t so;
    so = put(si, mk_err(e));
    so.halted = 1'b1;
    so.again  = 1'b0;
    return so;
  endfunction

  function automatic scan_t line_inc(input scan_t si);
    scan_t so;
    so = si;
    if (so.line != '1) begin
      so.line = so.line + LineW'(1);
    end
    return so;
  endfunction

  function automatic scan_t nest_up(input scan_t si);
    scan_t so;
    so = si;
    if (so.open_n >= NestCap) begin
      so = fail(so, ERR_NEST);
    end else begin
      so.open_n = so.open_n + NestW'(1);
    end
    return so;
  endfunction

  function automatic scan_t step(input scan_t si, input logic eos, input logic [7:0] c,
                                 input logic [WordDepth-1:0][7:0] wbuf);
    scan_t      r;
    logic       v;
    logic       str;
    logic [8:0] ev;
    logic [5:0] k;
    r   = si;
    v   = !eos;
    str = (si.mode == M_LONG_STR) || (si.mode == M_LONG_STR_CLOSE);
    ev  = esc_value(c);
    k   = single_kind(c);
    r.again = 1'b0;
    case (si.mode)
      M_IDLE: begin
        if (eos) begin
          r = put(r, mk_tok(TK_EOF, BASE_NONE));
        end else if (c == CH_NL) begin
          r = line_inc(r);
        end else if (c == " " || c == CH_CR || c == CH_TAB) begin
          r.again = 1'b0;
        end else if (is_letter(c)) begin
          r = put(r, mk_byte(c));
          r.wb_we   = 1'b1;
          r.wb_idx  = 3'd0;
          r.wb_data = c;
          r.wlen    = 4'd1;
          r.mode    = M_IDENT;
        end else if (is_digit(c)) begin
          r = put(r, mk_byte(c));
          r.mode = (c == "0") ? M_NUM_ZERO : M_NUM_DEC;
        end else if (k != TK_INVALID) begin
          r = put(r, mk_tok(k, BASE_NONE));
        end else begin
          case (c)
            "[":       r.mode = M_BRACKET;
            "-":       r.mode = M_MINUS;
            "~":       r.mode = M_TILDE;
            "=":       r.mode = M_EQ;
            "<":       r.mode = M_LT;
            ">":       r.mode = M_GT;
            ".":       r.mode = M_DOT1;
            "'", "\"": begin
              r.qd   = (c == "\"");
              r.mode = M_STR;
            end
            default:   r = fail(r, ERR_CHAR);
          endcase
        end
      end
      M_IDENT: begin
        if (v && is_word_char(c)) begin
          r = put(r, mk_byte(c));
          if (si.wlen < 4'd8) begin
            r.wb_we   = 1'b1;
            r.wb_idx  = si.wlen[2:0];
            r.wb_data = c;
          end
          if (si.wlen < 4'd15) begin
            r.wlen = si.wlen + 4'd1;
          end
        end else begin
          r = put(r, mk_tok(kw_kind(wbuf, si.wlen), BASE_NONE));
          r.mode  = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_NUM_ZERO: begin
        if (v && is_letter(c)) begin
          case (c)
            "b", "B": r.mode = M_P2;
            "o", "O": r.mode = M_P8;
            "d", "D": r.mode = M_P10;
            "x", "X": r.mode = M_P16;
            default:  r = fail(r, ERR_PREFIX);
          endcase
          if (!r.halted) begin
            r = put(r, mk_byte(c));
          end
        end else begin
          r.mode  = M_NUM_DEC;
          r.again = 1'b1;
        end
      end
      M_NUM_DEC: begin
        if (v && (is_digit(c) || c == ".")) begin
          r = put(r, mk_byte(c));
        end else if (v && (c == "e" || c == "E")) begin
          r = put(r, mk_byte(c));
          r.mode = M_NUM_EXP;
        end else begin
          r.mode  = M_NUM_TAIL;
          r.again = 1'b1;
        end
      end
      M_NUM_EXP: begin
        r.mode = M_NUM_EXPDIG;
        if (v && (c == "+" || c == "-")) begin
          r = put(r, mk_byte(c));
        end else begin
          r.again = 1'b1;
        end
      end
      M_NUM_EXPDIG: begin
        if (v && is_digit(c)) begin
          r = put(r, mk_byte(c));
        end else begin
          r.mode  = M_NUM_TAIL;
          r.again = 1'b1;
        end
      end
      M_NUM_TAIL, M_P2, M_P8, M_P10, M_P16: begin
        if (v && is_word_char(c)) begin
          r = put(r, mk_byte(c));
        end else begin
          r = put(r, mk_tok(TK_NUMBER,
                            (si.mode == M_P2)  ? BASE_2  :
                            (si.mode == M_P8)  ? BASE_8  :
                            (si.mode == M_P10) ? BASE_10 :
                            (si.mode == M_P16) ? BASE_16 : BASE_NONE));
          r.mode  = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_MINUS: begin
        if (v && c == "-") begin
          r.mode = M_CMT_START;
        end else begin
          r = put(r, mk_tok(TK_MINUS, BASE_NONE));
          r.mode  = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_CMT_START: begin
        if (v && c == CH_LBRACK) begin
          r.open_n = '0;
          r.mode   = M_CMT_BR;
        end else begin
          r.mode  = M_LINE_CMT;
          r.again = 1'b1;
        end
      end
      M_CMT_BR: begin
        if (v && c == CH_EQUAL) begin
          r = nest_up(r);
        end else if (v && c == CH_LBRACK) begin
          r.mode = M_LONG_CMT;
        end else begin
          r.mode  = M_LINE_CMT;
          r.again = 1'b1;
        end
      end
      M_LINE_CMT: begin
        if (eos) begin
          r.mode  = M_IDLE;
          r.again = 1'b1;
        end else if (c == CH_NL) begin
          r = line_inc(r);
          r.mode = M_IDLE;
        end
      end
      M_LONG_CMT, M_LONG_STR: begin
        if (eos) begin
          r = fail(r, ERR_LONG_OPEN);
        end else if (c == CH_RBRACK) begin
          r.close_n = '0;
          r.mode    = str ? M_LONG_STR_CLOSE : M_LONG_CMT_CLOSE;
        end else begin
          if (str) begin
            r = put(r, mk_byte(c));
          end
          if (c == CH_NL) begin
            r = line_inc(r);
          end
        end
      end
      M_LONG_CMT_CLOSE, M_LONG_STR_CLOSE: begin
        if (eos) begin
          r = fail(r, ERR_LONG_OPEN);
        end else if (c == CH_EQUAL) begin
          if (si.close_n < si.open_n) begin
            r.close_n = si.close_n + NestW'(1);
          end else begin
            if (str) begin
              r.rep_len = 5'(si.close_n) + 5'd1;
              r = put(r, mk_byte(CH_EQUAL));
            end
            r.close_n = '0;
            r.mode    = str ? M_LONG_STR : M_LONG_CMT;
          end
        end else if (c == CH_RBRACK) begin
          if (si.close_n == si.open_n) begin
            if (str) begin
              r = put(r, mk_tok(TK_STRING, BASE_NONE));
            end
            r.mode = M_IDLE;
          end else begin
            if (str) begin
              r.rep_len = 5'(si.close_n) + 5'd1;
            end
            r.close_n = '0;
          end
        end else begin
          if (str) begin
            r.rep_len = 5'(si.close_n) + 5'd1;
          end
          r.close_n = '0;
          r.mode    = str ? M_LONG_STR : M_LONG_CMT;
          r.again   = 1'b1;
        end
      end
      M_BRACKET: begin
        if (v && c == CH_LBRACK) begin
          r.open_n = '0;
          r.mode   = M_LONG_STR;
        end else if (v && c == CH_EQUAL) begin
          r.open_n = '0;
          r = nest_up(r);
          r.mode = M_BRACKET_EQ;
        end else begin
          r = put(r, mk_tok(TK_LBRACK, BASE_NONE));
          r.mode  = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_BRACKET_EQ: begin
        if (v && c == CH_EQUAL) begin
          r = nest_up(r);
        end else if (v && c == CH_LBRACK) begin
          r.mode = M_LONG_STR;
        end else begin
          r = fail(r, ERR_NO_LBRACK);
        end
      end
      M_EQ, M_LT, M_GT: begin
        r.mode = M_IDLE;
        if (v && c == CH_EQUAL) begin
          r = put(r, mk_tok((si.mode == M_EQ) ? TK_EQEQ :
                            (si.mode == M_LT) ? TK_LE : TK_GE, BASE_NONE));
        end else begin
          r = put(r, mk_tok((si.mode == M_EQ) ? TK_ASSIGN :
                            (si.mode == M_LT) ? TK_LT : TK_GT, BASE_NONE));
          r.again = 1'b1;
        end
      end
      M_TILDE: begin
        if (v && c == CH_EQUAL) begin
          r = put(r, mk_tok(TK_NE, BASE_NONE));
          r.mode = M_IDLE;
        end else begin
          r = fail(r, ERR_NO_EQUAL);
        end
      end
      M_DOT1: begin
        if (v && c == ".") begin
          r.mode = M_DOT2;
        end else if (v && is_digit(c)) begin
          r = put(r, mk_byte("."));
          r = put(r, mk_byte(c));
          r.mode = M_NUM_DEC;
        end else begin
          r = put(r, mk_tok(TK_DOT, BASE_NONE));
          r.mode  = M_IDLE;
          r.again = 1'b1;
        end
      end
      M_DOT2: begin
        r.mode = M_IDLE;
        if (v && c == ".") begin
          r = put(r, mk_tok(TK_DOTS, BASE_NONE));
        end else begin
          r = put(r, mk_tok(TK_CONCAT, BASE_NONE));
          r.again = 1'b1;
        end
      end
      M_STR: begin
        if (eos || c == CH_NL) begin
          r = fail(r, ERR_STR_OPEN);
        end else if (c == (si.qd ? 8'("\"") : 8'("'"))) begin
          r = put(r, mk_tok(TK_STRING, BASE_NONE));
          r.mode = M_IDLE;
        end else if (c == "\\") begin
          r.mode = M_STR_ESC;
        end else begin
          r = put(r, mk_byte(c));
        end
      end
      M_STR_ESC: begin
        if (eos || !ev[8]) begin
          r = fail(r, ERR_ESCAPE);
        end else begin
          if (c == CH_NL) begin
            r = line_inc(r);
            r.use_new = 1'b1;
          end
          r = put(r, mk_byte(ev[7:0]));
          r.mode = M_STR;
        end
      end
      default: begin
        r.mode  = M_IDLE;
        r.again = 1'b1;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    s = '0;
    s.mode    = mode;
    s.line    = line_count;
    s.open_n  = open_nesting;
    s.close_n = close_nesting;
    s.qd      = quote_is_double;
    s.wlen    = word_length;
    s.halted  = halted;
    s.again   = 1'b1;
    for (int it = 0; it < 4; it++) begin
      if (s.again && !s.halted) begin
        s = step(s, end_of_stream, source_byte, word_buffer);
      end
    end
  end

  always_comb begin
    desc.rep_len = s.rep_len;
    desc.total   = s.rep_len + 5'(s.n);
    desc.slot    = s.slot;
    desc.line    = s.use_new ? s.line : line_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= M_IDLE;
      line_count      <= LineW'(1);
      open_nesting    <= '0;
      close_nesting   <= '0;
      quote_is_double <= 1'b0;
      word_length     <= '0;
      halted          <= 1'b0;
    end else if (accept) begin
      mode            <= s.mode;
      line_count      <= s.line;
      open_nesting    <= s.open_n;
      close_nesting   <= s.close_n;
      quote_is_double <= s.qd;
      word_length     <= s.wlen;
      halted          <= s.halted;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s.wb_we) begin
      word_buffer[s.wb_idx] <= s.wb_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/lst_emit.sv -----
// ----------------------------------------------------------------------------
// lst_emit
// Result register: holds one descriptor and delivers its results one per
// handshake, close replay bytes first.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_emit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire lst_pkg::desc_t          desc_in,
  output logic                         take,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         is_token,
  output logic [5:0]                   token_kind,
  output logic [lst_pkg::LineW-1:0]    line_number,
  output logic [7:0]                   payload_byte,
  output logic [4:0]                   number_base,
  output logic [3:0]                   error_code,
  output logic                         last_of_run
);
  import lst_pkg::*;

  desc_t      desc;
  logic       valid;
  logic [4:0] idx;
  logic [4:0] sidx;
  res_t       cur;
  logic       last;

  always_comb begin
    sidx = idx - desc.rep_len;
    if (idx < desc.rep_len) begin
      cur = mk_byte((idx == 5'd0) ? CH_RBRACK : CH_EQUAL);
    end else begin
      cur = desc.slot[sidx[0]];
    end
    last = (idx == desc.total - 5'd1);
  end

  assign take         = !valid || (out_ready && last);
  assign out_valid    = valid;
  assign is_token     = cur.is_token;
  assign token_kind   = cur.kind;
  assign line_number  = desc.line;
  assign payload_byte = cur.payload;
  assign number_base  = cur.base;
  assign error_code   = cur.err;
  assign last_of_run  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= (desc_in.total != 5'd0);
      idx   <= '0;
    end else if (valid && out_ready) begin
      if (last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
    end
  end

endmodule

`default_nettype wire

// ----- design/lua_style_tokenizer.sv -----
// ----------------------------------------------------------------------------
// lua_style_tokenizer
// Lua-style source tokenizer: bytes in, payload bytes and tokens out.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   source_byte, end_of_stream
//   out      out_valid / out_ready is_token, token_kind, line_number,
//                                  payload_byte, number_base, error_code,
//                                  last_of_run
//
// One byte is scanned per cycle into a result register while out_ready is
// high and no byte gives more than one result; a byte is taken in the same
// cycle its predecessor's last result leaves, so the next byte waits until
// all results have left (up to 17, set by the long bracket close replay).
// Synchronous reset; an error holds the block silent until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lua_style_tokenizer #(
  parameter int unsigned MAX_NEST = lst_pkg::MaxNestDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              source_byte,
  input  wire logic                    end_of_stream,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         is_token,
  output logic [5:0]                   token_kind,
  output logic [lst_pkg::LineW-1:0]    line_number,
  output logic [7:0]                   payload_byte,
  output logic [4:0]                   number_base,
  output logic [3:0]                   error_code,
  output logic                         last_of_run
);
  import lst_pkg::*;

  desc_t desc;
  logic  take;
  logic  accept;

  assign in_ready = take;
  assign accept   = in_valid && take;

  lst_scan #(
    .MAX_NEST (MAX_NEST)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .source_byte   (source_byte),
    .end_of_stream (end_of_stream),
    .desc          (desc)
  );

  lst_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .desc_in      (desc),
    .take         (take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_token     (is_token),
    .token_kind   (token_kind),
    .line_number  (line_number),
    .payload_byte (payload_byte),
    .number_base  (number_base),
    .error_code   (error_code),
    .last_of_run  (last_of_run)
  );

endmodule

`default_nettype wire
